/* sv/fre_pkg.sv */
// Shared types and constants for the fragment reassembly engine.
// Holds status codes, register indexes, parameter defaults and the
// command/status structs between controller and datapath.
package fre_pkg;

    localparam int DEF_MAX_FRAGMENTS  = 8;
    localparam int DEF_FRAG_PAYLOAD   = 16;
    localparam int DEF_MESSAGE_BYTES  = 64;

    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MESSAGE_BYTES  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAGMENT_TOTAL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAG_PAYLOAD   = 2'd2;

    localparam logic [3:0] ST_ACCEPTED    = 4'd0;
    localparam logic [3:0] ST_DUPLICATE   = 4'd1;
    localparam logic [3:0] ST_COMPLETE    = 4'd2;
    localparam logic [3:0] ST_BAD_CONFIG  = 4'd3;
    localparam logic [3:0] ST_ZERO_COUNT  = 4'd4;
    localparam logic [3:0] ST_COUNT_LARGE = 4'd5;
    localparam logic [3:0] ST_ZERO_INDEX  = 4'd6;
    localparam logic [3:0] ST_INDEX_RANGE = 4'd7;
    localparam logic [3:0] ST_EMPTY       = 4'd8;
    localparam logic [3:0] ST_FRAG_LARGE  = 4'd9;
    localparam logic [3:0] ST_MISMATCH    = 4'd10;
    localparam logic [3:0] ST_CONFLICT    = 4'd11;
    localparam logic [3:0] ST_MSG_LARGE   = 4'd12;

    typedef struct packed {
        logic       stage_wr;
        logic       latch;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       mem_rd;
        logic       copy_wr;
        logic       commit;
        logic       sel_drain;
        logic       frag_clr;
        logic       frag_inc;
        logic       xfer_clr;
        logic       out_load;
        logic       out_last;
        logic [3:0] out_code;
    } fre_cmd_t;

    typedef struct packed {
        logic       pre_err;
        logic [3:0] pre_code;
        logic       dup_path;
        logic       len_match;
        logic       cmp_eq;
        logic       cnt_last;
        logic       msg_large;
        logic       xfer_done;
        logic       frag_last;
        logic       byte_last;
        logic       out_free;
    } fre_sts_t;

endpackage

/* sv/fragment_reassembly_engine_core.sv */
// Top level of the fragment reassembly engine.
// Instantiates fre_ctrl and fre_datapath; uses fre_pkg.
//
//  channel | signals                                  | direction
//  in      | in_valid, in_stall, frag_index .. end    | item in
//  out     | out_valid, out_stall, status .. total    | item out
//  cfg     | cfg_valid, cfg_ready, cfg_index, data    | register write
//
// A byte without fragment_end is staged and the engine stays idle. A fragment
// end that a check rejects is reported from the check state; a duplicate is
// compared byte by byte with its slot, and an accepted fragment is copied byte
// by byte into its slot and committed. A completing fragment then drains the
// message via the registered slot memory read. Reset clears all control state;
// memories need no clearing. A stalled output holds the controller.
module fragment_reassembly_engine_core
    import fre_pkg::*;
#(
    parameter int MAX_FRAGMENTS  = DEF_MAX_FRAGMENTS,
    parameter int FRAG_PAYLOAD   = DEF_FRAG_PAYLOAD,
    parameter int MESSAGE_BYTES  = DEF_MESSAGE_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [15:0]            frag_index,
    input  logic [15:0]            frag_total,
    input  logic [7:0]             payload_byte,
    input  logic                   byte_present,
    input  logic                   fragment_end,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [3:0]             status,
    output logic [7:0]             out_byte,
    output logic                   out_byte_valid,
    output logic                   run_last,
    output logic [15:0]            report_index,
    output logic [15:0]            report_total,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    fre_cmd_t cmd;
    fre_sts_t sts;

    assign cfg_ready = 1'b1;

    fre_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .fragment_end (fragment_end),
        .in_stall     (in_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    fre_datapath #(
        .MAX_FRAGMENTS  (MAX_FRAGMENTS),
        .FRAG_PAYLOAD   (FRAG_PAYLOAD),
        .MESSAGE_BYTES  (MESSAGE_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .frag_index     (frag_index),
        .frag_total     (frag_total),
        .payload_byte   (payload_byte),
        .byte_present   (byte_present),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .out_byte       (out_byte),
        .out_byte_valid (out_byte_valid),
        .run_last       (run_last),
        .report_index   (report_index),
        .report_total   (report_total),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

/* sv/fre_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/fre_ctrl.sv */
// Controller state machine of the fragment reassembly engine.
// Depends on fre_pkg for the command and status structs.
module fre_ctrl
    import fre_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     fragment_end,
    output logic     in_stall,
    input  fre_sts_t sts,
    output fre_cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PRE    = 4'd1;
    localparam logic [3:0] S_CMP_RD = 4'd2;
    localparam logic [3:0] S_CMP_EV = 4'd3;
    localparam logic [3:0] S_CP_RD  = 4'd4;
    localparam logic [3:0] S_CP_WR  = 4'd5;
    localparam logic [3:0] S_COMMIT = 4'd6;
    localparam logic [3:0] S_DR_RD  = 4'd7;
    localparam logic [3:0] S_DR_EV  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.stage_wr = 1'b1;
                    if (fragment_end)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = S_PRE;
                    end
                end
            end
            S_PRE:
            begin
                if (sts.pre_err)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_last = 1'b1;
                        cmd.out_code = sts.pre_code;
                        state_next   = S_IDLE;
                    end
                end
                else if (sts.dup_path)
                begin
                    if (sts.len_match)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_CMP_RD;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_last = 1'b1;
                        cmd.out_code = ST_CONFLICT;
                        state_next   = S_IDLE;
                    end
                end
                else if (sts.msg_large)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_last = 1'b1;
                        cmd.out_code = ST_MSG_LARGE;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_CP_RD;
                end
            end
            S_CMP_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_CMP_EV;
            end
            S_CMP_EV:
            begin
                if (!sts.cmp_eq || sts.cnt_last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_last = 1'b1;
                        cmd.out_code = sts.cmp_eq ? ST_DUPLICATE : ST_CONFLICT;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_CMP_RD;
                end
            end
            S_CP_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                cmd.copy_wr = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_CP_RD;
                end
            end
            S_COMMIT:
            begin
                if (sts.xfer_done)
                begin
                    cmd.commit   = 1'b1;
                    cmd.frag_clr = 1'b1;
                    cmd.cnt_clr  = 1'b1;
                    state_next   = S_DR_RD;
                end
                else if (sts.out_free)
                begin
                    cmd.commit   = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_code = ST_ACCEPTED;
                    state_next   = S_IDLE;
                end
            end
            S_DR_RD:
            begin
                cmd.sel_drain = 1'b1;
                cmd.mem_rd    = 1'b1;
                state_next    = S_DR_EV;
            end
            S_DR_EV:
            begin
                cmd.sel_drain = 1'b1;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_code = ST_COMPLETE;
                    cmd.out_last = sts.byte_last && sts.frag_last;
                    if (sts.byte_last)
                    begin
                        if (sts.frag_last)
                        begin
                            cmd.xfer_clr = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            cmd.frag_inc = 1'b1;
                            cmd.cnt_clr  = 1'b1;
                            state_next   = S_DR_RD;
                        end
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = S_DR_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/fre_datapath.sv */
// Datapath of the fragment reassembly engine: configuration, staging,
// slot storage, checks and the output register. Uses fre_pkg and fre_ram.
module fre_datapath
    import fre_pkg::*;
#(
    parameter int MAX_FRAGMENTS  = DEF_MAX_FRAGMENTS,
    parameter int FRAG_PAYLOAD   = DEF_FRAG_PAYLOAD,
    parameter int MESSAGE_BYTES  = DEF_MESSAGE_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [15:0]            frag_index,
    input  logic [15:0]            frag_total,
    input  logic [7:0]             payload_byte,
    input  logic                   byte_present,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [3:0]             status,
    output logic [7:0]             out_byte,
    output logic                   out_byte_valid,
    output logic                   run_last,
    output logic [15:0]            report_index,
    output logic [15:0]            report_total,
    input  fre_cmd_t               cmd,
    output fre_sts_t               sts
);

    localparam int AW  = (FRAG_PAYLOAD > 1) ? $clog2(FRAG_PAYLOAD) : 1;
    localparam int LW  = $clog2(FRAG_PAYLOAD + 2);
    localparam int SW  = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam int RW  = $clog2(MAX_FRAGMENTS + 1);
    localparam int SLOTS = MAX_FRAGMENTS * FRAG_PAYLOAD;
    localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ACW = $clog2(MESSAGE_BYTES + 1);

    logic [6:0]      mmb_reg;
    logic [3:0]      mft_reg;
    logic [4:0]      mfb_reg;
    logic [LW-1:0]   stage_len_reg;
    logic [LW-1:0]   stage_len_next;
    logic [15:0]     idx_reg;
    logic [15:0]     tot_reg;
    logic [LW-1:0]   len_reg;
    logic [AW-1:0]   cnt_reg;
    logic [SW-1:0]   frag_reg;
    logic [LW-1:0]   slot_len_reg [MAX_FRAGMENTS];
    logic [MAX_FRAGMENTS-1:0] filled_reg;
    logic            active_reg;
    logic [RW-1:0]   expected_reg;
    logic [RW-1:0]   received_reg;
    logic [ACW-1:0]  acc_reg;
    logic            out_valid_reg;
    logic [3:0]      status_reg;
    logic [7:0]      out_byte_reg;
    logic            out_byte_valid_reg;
    logic            run_last_reg;
    logic [15:0]     report_index_reg;
    logic [15:0]     report_total_reg;

    logic [SW-1:0]   cur_slot;
    logic [SW-1:0]   rd_slot;
    logic [LW-1:0]   rd_slot_len;
    logic            stage_we;
    logic [7:0]      stage_rdata;
    logic [7:0]      slot_rdata;
    logic [SAW-1:0]  slot_waddr;
    logic [SAW-1:0]  slot_raddr;
    logic            cfg_ok;
    logic            echo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mmb_reg <= 7'd64;
            mft_reg <= 4'd8;
            mfb_reg <= 5'd16;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_MESSAGE_BYTES:  mmb_reg <= cfg_data;
                CFG_MAX_FRAGMENT_TOTAL: mft_reg <= cfg_data[3:0];
                CFG_MAX_FRAG_PAYLOAD:   mfb_reg <= cfg_data[4:0];
                default:                mmb_reg <= mmb_reg;
            endcase
        end
    end

    assign stage_we = cmd.stage_wr && byte_present
                      && (32'(stage_len_reg) < 32'(FRAG_PAYLOAD));

    always_comb
    begin
        stage_len_next = stage_len_reg;
        if (cmd.stage_wr && byte_present
            && (32'(stage_len_reg) <= 32'(FRAG_PAYLOAD)))
        begin
            stage_len_next = stage_len_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_len_reg <= '0;
        end
        else if (cmd.latch)
        begin
            stage_len_reg <= '0;
        end
        else
        begin
            stage_len_reg <= stage_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            idx_reg <= frag_index;
            tot_reg <= frag_total;
            len_reg <= stage_len_next;
        end
        if (cmd.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + AW'(1);
        end
        if (cmd.frag_clr)
        begin
            frag_reg <= '0;
        end
        else if (cmd.frag_inc)
        begin
            frag_reg <= frag_reg + SW'(1);
        end
        if (cmd.commit)
        begin
            slot_len_reg[cur_slot] <= len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg   <= '0;
            active_reg   <= 1'b0;
            expected_reg <= '0;
            received_reg <= '0;
            acc_reg      <= '0;
        end
        else if (cmd.xfer_clr)
        begin
            filled_reg   <= '0;
            active_reg   <= 1'b0;
            expected_reg <= '0;
            received_reg <= '0;
            acc_reg      <= '0;
        end
        else if (cmd.commit)
        begin
            filled_reg[cur_slot] <= 1'b1;
            active_reg           <= 1'b1;
            if (!active_reg)
            begin
                expected_reg <= RW'(tot_reg);
            end
            received_reg <= received_reg + RW'(1);
            acc_reg      <= ACW'(32'(acc_reg) + 32'(len_reg));
        end
    end

    assign cur_slot    = SW'(idx_reg - 16'd1);
    assign rd_slot     = cmd.sel_drain ? frag_reg : cur_slot;
    assign rd_slot_len = slot_len_reg[rd_slot];
    assign slot_waddr  = SAW'(32'(cur_slot) * FRAG_PAYLOAD + 32'(cnt_reg));
    assign slot_raddr  = SAW'(32'(rd_slot) * FRAG_PAYLOAD + 32'(cnt_reg));

    fre_ram #(
        .WIDTH (8),
        .DEPTH (FRAG_PAYLOAD)
    ) u_stage_ram (
        .clk   (clk),
        .we    (stage_we),
        .waddr (stage_len_reg[AW-1:0]),
        .wdata (payload_byte),
        .re    (cmd.mem_rd),
        .raddr (cnt_reg),
        .rdata (stage_rdata)
    );

    fre_ram #(
        .WIDTH (8),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (cmd.copy_wr),
        .waddr (slot_waddr),
        .wdata (stage_rdata),
        .re    (cmd.mem_rd),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign cfg_ok = (mmb_reg != 7'd0) && (32'(mmb_reg) <= 32'(MESSAGE_BYTES))
                 && (mft_reg != 4'd0) && (32'(mft_reg) <= 32'(MAX_FRAGMENTS))
                 && (mfb_reg != 5'd0) && (32'(mfb_reg) <= 32'(FRAG_PAYLOAD));

    always_comb
    begin
        sts.pre_err  = 1'b1;
        sts.pre_code = ST_ACCEPTED;
        if (!cfg_ok)
        begin
            sts.pre_code = ST_BAD_CONFIG;
        end
        else if (tot_reg == 16'd0)
        begin
            sts.pre_code = ST_ZERO_COUNT;
        end
        else if (tot_reg > 16'(mft_reg))
        begin
            sts.pre_code = ST_COUNT_LARGE;
        end
        else if (idx_reg == 16'd0)
        begin
            sts.pre_code = ST_ZERO_INDEX;
        end
        else if (idx_reg > tot_reg)
        begin
            sts.pre_code = ST_INDEX_RANGE;
        end
        else if (len_reg == '0)
        begin
            sts.pre_code = ST_EMPTY;
        end
        else if (32'(len_reg) > 32'(mfb_reg))
        begin
            sts.pre_code = ST_FRAG_LARGE;
        end
        else if (active_reg && (32'(expected_reg) != 32'(tot_reg)))
        begin
            sts.pre_code = ST_MISMATCH;
        end
        else
        begin
            sts.pre_err = 1'b0;
        end
        sts.dup_path  = active_reg && filled_reg[cur_slot];
        sts.len_match = (rd_slot_len == len_reg);
        sts.cmp_eq    = (stage_rdata == slot_rdata);
        sts.cnt_last  = (32'(cnt_reg) + 32'd1 == 32'(len_reg));
        sts.msg_large = (32'(acc_reg) + 32'(len_reg) > 32'(mmb_reg));
        sts.xfer_done = (32'(received_reg) + 32'd1 == 32'(tot_reg));
        sts.frag_last = (32'(frag_reg) + 32'd1 == 32'(tot_reg));
        sts.byte_last = (32'(cnt_reg) + 32'd1 == 32'(rd_slot_len));
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    assign echo = (cmd.out_code >= ST_BAD_CONFIG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg         <= cmd.out_code;
            out_byte_valid_reg <= (cmd.out_code == ST_COMPLETE);
            out_byte_reg       <= (cmd.out_code == ST_COMPLETE) ? slot_rdata : 8'd0;
            run_last_reg       <= cmd.out_last;
            report_index_reg   <= echo ? idx_reg : 16'd0;
            report_total_reg   <= echo ? tot_reg : 16'd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign out_byte       = out_byte_reg;
    assign out_byte_valid = out_byte_valid_reg;
    assign run_last       = run_last_reg;
    assign report_index   = report_index_reg;
    assign report_total   = report_total_reg;

endmodule

/* tb/sv/fragment_reassembly_engine_core_test.sv */
// Testbench for fragment_reassembly_engine_core: directed table, then random
// messages with noise, checked against an in-bench reassembly predictor.
// Depends on fre_pkg and the engine RTL only.
module fragment_reassembly_engine_core_test;
    import fre_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 200;

    typedef struct {
        logic [15:0] idx;
        logic [15:0] tot;
        logic [7:0]  pbyte;
        logic        pres;
        logic        fend;
    } frag_item_t;

    typedef struct {
        logic [3:0]  code;
        logic [7:0]  obyte;
        logic        obvalid;
        logic        last;
        logic [15:0] ridx;
        logic [15:0] rtot;
    } frag_result_t;

    typedef struct {
        logic [15:0] idx;
        logic [15:0] tot;
        logic [7:0]  pbyte;
        logic        pres;
        logic        fend;
        int          rep;
        bit          chk;
        logic [3:0]  code;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [15:0]            frag_index = '0;
    logic [15:0]            frag_total = '0;
    logic [7:0]             payload_byte = '0;
    logic                   byte_present = 1'b0;
    logic                   fragment_end = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [3:0]             status;
    logic [7:0]             out_byte;
    logic                   out_byte_valid;
    logic                   run_last;
    logic [15:0]            report_index;
    logic [15:0]            report_total;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    fragment_reassembly_engine_core DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [7:0]   stage_mem [16];
    int           stage_len;
    logic [7:0]   slot_mem [8][16];
    int           slot_len [8];
    bit           slot_full [8];
    bit           xfer_on;
    int           want_total;
    int           got_total;
    int           msg_bytes;
    int           lim_msg = 64;
    int           lim_tot = 8;
    int           lim_frag = 16;
    logic [3:0]   last_code;

    frag_result_t pending [$];
    int           fails = 0;
    int           n_items = 0;
    bit           quiet = 1'b0;
    int           idle_cycles = 0;

    function automatic bit limits_good();
        return lim_msg > 0 && lim_msg <= 64 && lim_tot > 0 && lim_tot <= 8 &&
               lim_frag > 0 && lim_frag <= 16;
    endfunction

    function automatic logic [3:0] judge_fragment(int idx, int tot, int len);
        int  s;
        bit  same;
        if (!limits_good()) return ST_BAD_CONFIG;
        if (tot == 0) return ST_ZERO_COUNT;
        if (tot > lim_tot) return ST_COUNT_LARGE;
        if (idx == 0) return ST_ZERO_INDEX;
        if (idx > tot) return ST_INDEX_RANGE;
        if (len == 0) return ST_EMPTY;
        if (len > lim_frag) return ST_FRAG_LARGE;
        if (xfer_on && want_total != tot) return ST_MISMATCH;
        s = idx - 1;
        if (xfer_on && slot_full[s])
        begin
            same = (slot_len[s] == len);
            for (int i = 0; i < len && same; i++)
                if (slot_mem[s][i] != stage_mem[i]) same = 1'b0;
            return same ? ST_DUPLICATE : ST_CONFLICT;
        end
        if (msg_bytes + len > lim_msg) return ST_MSG_LARGE;
        return ST_ACCEPTED;
    endfunction

    function automatic void push_result(logic [3:0] c, logic [7:0] b, logic v, logic l,
                                        logic [15:0] ri, logic [15:0] rt);
        frag_result_t r;
        r.code = c; r.obyte = b; r.obvalid = v; r.last = l; r.ridx = ri; r.rtot = rt;
        pending.push_back(r);
    endfunction

    function automatic void reassemble_step(frag_item_t it);
        int         len;
        int         s;
        logic [3:0] c;
        if (it.pres)
        begin
            if (stage_len < 16) stage_mem[stage_len] = it.pbyte;
            if (stage_len <= 16) stage_len++;
        end
        if (!it.fend) return;
        len = stage_len;
        stage_len = 0;
        c = judge_fragment(it.idx, it.tot, len);
        last_code = c;
        if (c == ST_DUPLICATE)
        begin
            push_result(ST_DUPLICATE, 8'd0, 1'b0, 1'b1, 16'd0, 16'd0);
            return;
        end
        if (c != ST_ACCEPTED)
        begin
            push_result(c, 8'd0, 1'b0, 1'b1, it.idx, it.tot);
            return;
        end
        s = it.idx - 1;
        if (!xfer_on)
        begin
            xfer_on = 1'b1;
            want_total = it.tot;
        end
        for (int i = 0; i < len; i++) slot_mem[s][i] = stage_mem[i];
        slot_len[s] = len;
        slot_full[s] = 1'b1;
        msg_bytes += len;
        got_total++;
        if (got_total != it.tot)
        begin
            push_result(ST_ACCEPTED, 8'd0, 1'b0, 1'b1, 16'd0, 16'd0);
            return;
        end
        last_code = ST_COMPLETE;
        for (int f = 0; f < it.tot; f++)
            for (int i = 0; i < slot_len[f]; i++)
                push_result(ST_COMPLETE, slot_mem[f][i], 1'b1, 1'b0, 16'd0, 16'd0);
        pending[$].last = 1'b1;
        foreach (slot_full[f]) slot_full[f] = 1'b0;
        xfer_on = 1'b0;
        want_total = 0;
        got_total = 0;
        msg_bytes = 0;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing expected, status %0d", $time, status);
                fails++;
            end
            else
            begin
                frag_result_t e;
                e = pending.pop_front();
                if (status !== e.code)
                begin
                    $display("%0t: status exp %0d got %0d", $time, e.code, status);
                    fails++;
                end
                if (out_byte !== e.obyte)
                begin
                    $display("%0t: out_byte exp %h got %h", $time, e.obyte, out_byte);
                    fails++;
                end
                if (out_byte_valid !== e.obvalid)
                begin
                    $display("%0t: out_byte_valid exp %b got %b", $time, e.obvalid,
                             out_byte_valid);
                    fails++;
                end
                if (run_last !== e.last)
                begin
                    $display("%0t: run_last exp %b got %b", $time, e.last, run_last);
                    fails++;
                end
                if (report_index !== e.ridx)
                begin
                    $display("%0t: report_index exp %0d got %0d", $time, e.ridx,
                             report_index);
                    fails++;
                end
                if (report_total !== e.rtot)
                begin
                    $display("%0t: report_total exp %0d got %0d", $time, e.rtot,
                             report_total);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 8);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic drive_item(frag_item_t it);
        in_valid     <= 1'b1;
        frag_index   <= it.idx;
        frag_total   <= it.tot;
        payload_byte <= it.pbyte;
        byte_present <= it.pres;
        fragment_end <= it.fend;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_items++;
        reassemble_step(it);
        if (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] ix, int v);
        cfg_valid <= 1'b1;
        cfg_index <= ix;
        cfg_data  <= v[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (ix == CFG_MAX_MESSAGE_BYTES) lim_msg = v & 'h7f;
        else if (ix == CFG_MAX_FRAGMENT_TOTAL) lim_tot = v & 'hf;
        else if (ix == CFG_MAX_FRAG_PAYLOAD) lim_frag = v & 'h1f;
        @(posedge clk);
    endtask

    task automatic set_limits(int m, int t, int f);
        wait_drain();
        repeat (SETTLE) @(posedge clk);
        write_reg(CFG_MAX_MESSAGE_BYTES, m);
        write_reg(CFG_MAX_FRAGMENT_TOTAL, t);
        write_reg(CFG_MAX_FRAG_PAYLOAD, f);
    endtask

    task automatic send_framed(int idx, int tot, logic [7:0] data [$]);
        frag_item_t it;
        for (int i = 0; i < data.size(); i++)
        begin
            it.idx = (i == data.size() - 1) ? idx : $urandom;
            it.tot = (i == data.size() - 1) ? tot : $urandom;
            it.pbyte = data[i]; it.pres = 1'b1;
            it.fend = (i == data.size() - 1) && $urandom_range(1);
            drive_item(it);
            if (it.fend) return;
        end
        it.idx = idx; it.tot = tot; it.pbyte = $urandom; it.pres = 1'b0; it.fend = 1'b1;
        drive_item(it);
    endtask

    task automatic send_noise();
        logic [7:0] data [$];
        int         n;
        int         idx;
        int         tot;
        n = $urandom_range(0, 18);
        repeat (n) data.push_back($urandom);
        idx = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(0, 9);
        tot = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(0, 9);
        send_framed(idx, tot, data);
    endtask

    task automatic fill_gaps();
        logic [7:0] one [$];
        for (int pass = 0; pass < 2 && xfer_on && limits_good(); pass++)
            for (int f = 0; f < want_total && xfer_on; f++)
                if (!slot_full[f])
                begin
                    one.delete();
                    one.push_back($urandom);
                    send_framed(f + 1, want_total, one);
                end
    endtask

    task automatic run_message();
        logic [7:0] frag [8][$];
        int         order [8];
        int         tot;
        int         maxlen;
        int         len;
        int         j;
        int         k;
        logic [7:0] alt [$];
        if (!limits_good() || $urandom_range(99) < 10)
        begin
            send_noise();
            return;
        end
        if (pending.size() != 0 && $urandom_range(99) < 10) wait_drain();
        tot = $urandom_range(1, lim_tot);
        if (tot > lim_msg) tot = lim_msg;
        maxlen = lim_msg / tot;
        if (maxlen > lim_frag) maxlen = lim_frag;
        if ($urandom_range(99) < 85 && maxlen > 4) maxlen = 4;
        for (int f = 0; f < tot; f++)
        begin
            len = $urandom_range(1, maxlen);
            repeat (len) frag[f].push_back($urandom);
            order[f] = f;
        end
        for (int f = tot - 1; f > 0; f--)
        begin
            j = $urandom_range(0, f);
            k = order[f]; order[f] = order[j]; order[j] = k;
        end
        for (int f = 0; f < tot; f++)
        begin
            send_framed(order[f] + 1, tot, frag[order[f]]);
            if (f < tot - 1 && $urandom_range(99) < 12)
            begin
                alt = frag[order[f]];
                if ($urandom_range(1)) alt[$urandom_range(0, alt.size() - 1)] ^= 8'h01 <<
                    $urandom_range(7);
                send_framed(order[f] + 1, tot, alt);
            end
        end
        fill_gaps();
    endtask

    dir_row_t table_rows [] = '{
        '{16'd1, 16'd0, 8'h11, 1'b1, 1'b1, 1, 1'b1, ST_ZERO_COUNT},
        '{16'd1, 16'd9, 8'h22, 1'b1, 1'b1, 1, 1'b1, ST_COUNT_LARGE},
        '{16'd0, 16'd2, 8'h33, 1'b1, 1'b1, 1, 1'b1, ST_ZERO_INDEX},
        '{16'd3, 16'd2, 8'h44, 1'b1, 1'b1, 1, 1'b1, ST_INDEX_RANGE},
        '{16'd1, 16'd2, 8'hff, 1'b0, 1'b1, 1, 1'b1, ST_EMPTY},
        '{16'hffff, 16'hffff, 8'hff, 1'b1, 1'b1, 1, 1'b1, ST_COUNT_LARGE},
        '{16'd2, 16'd2, 8'haa, 1'b1, 1'b1, 1, 1'b1, ST_ACCEPTED},
        '{16'd2, 16'd2, 8'haa, 1'b1, 1'b1, 1, 1'b1, ST_DUPLICATE},
        '{16'd2, 16'd2, 8'hbb, 1'b1, 1'b1, 1, 1'b1, ST_CONFLICT},
        '{16'd1, 16'd3, 8'h5a, 1'b1, 1'b1, 1, 1'b1, ST_MISMATCH},
        '{16'd1, 16'd2, 8'h00, 1'b1, 1'b1, 3, 1'b1, ST_COMPLETE},
        '{16'd1, 16'd1, 8'h55, 1'b1, 1'b1, 17, 1'b1, ST_FRAG_LARGE},
        '{16'd1, 16'd9, 8'h00, 1'b1, 1'b1, 16, 1'b1, ST_COUNT_LARGE},
        '{16'd1, 16'd5, 8'h01, 1'b1, 1'b1, 15, 1'b1, ST_ACCEPTED},
        '{16'd2, 16'd5, 8'h02, 1'b1, 1'b1, 15, 1'b1, ST_ACCEPTED},
        '{16'd3, 16'd5, 8'h03, 1'b1, 1'b1, 15, 1'b1, ST_ACCEPTED},
        '{16'd4, 16'd5, 8'h04, 1'b1, 1'b1, 15, 1'b1, ST_ACCEPTED},
        '{16'd5, 16'd5, 8'h05, 1'b1, 1'b1, 5, 1'b1, ST_MSG_LARGE},
        '{16'd5, 16'd5, 8'hfe, 1'b1, 1'b1, 4, 1'b1, ST_COMPLETE},
        '{16'd4, 16'd4, 8'h80, 1'b1, 1'b0, 2, 1'b0, ST_ACCEPTED},
        '{16'd1, 16'd1, 8'h7f, 1'b1, 1'b1, 1, 1'b0, ST_ACCEPTED}
    };

    task automatic walk_table();
        frag_item_t it;
        foreach (table_rows[r])
        begin
            for (int n = 0; n < table_rows[r].rep; n++)
            begin
                it.idx = table_rows[r].idx;
                it.tot = table_rows[r].tot;
                it.pbyte = table_rows[r].pbyte;
                it.pres = table_rows[r].pres;
                it.fend = table_rows[r].fend && (n == table_rows[r].rep - 1);
                drive_item(it);
            end
            if (table_rows[r].chk && last_code != table_rows[r].code)
            begin
                $display("%0t: row %0d status exp %0d got %0d", $time, r,
                         table_rows[r].code, last_code);
                fails++;
            end
        end
    endtask

    task automatic random_phase(int count);
        int target;
        target = n_items + count;
        while (n_items < target) run_message();
        fill_gaps();
    endtask

    initial
    begin
        stage_len = 0;
        foreach (slot_full[f]) slot_full[f] = 1'b0;
        xfer_on = 1'b0; want_total = 0; got_total = 0; msg_bytes = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        walk_table();
        set_limits(20, 3, 5);
        random_phase(8);
        set_limits(0, 8, 16);
        random_phase(2);
        set_limits(64, 0, 16);
        random_phase(2);
        set_limits(64, 8, 0);
        random_phase(2);
        set_limits(127, 127, 127);
        random_phase(2);
        set_limits(1, 1, 1);
        wait_drain();
        random_phase(4);
        set_limits(64, 8, 16);
        quiet = 1'b1;
        random_phase(10);
        quiet = 1'b0;
        random_phase(10);
        wait_drain();
        repeat (SETTLE) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* fragment_reassembly_engine_core.f */
sv/fre_pkg.sv
sv/fre_ram.sv
sv/fre_ctrl.sv
sv/fre_datapath.sv
sv/fragment_reassembly_engine_core.sv
tb/sv/fragment_reassembly_engine_core_test.sv
